// ===== rtl/scle_pkg.sv =====
// Shared constants, codes and controller/datapath handshake structs for the
// serial command line editor. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scle_pkg;

   // Line store geometry
   localparam int LINE_DEPTH = 32;
   localparam int LEN_W      = $clog2(LINE_DEPTH);
   localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(LINE_DEPTH - 2);

   // Character codes
   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_SP  = 8'h20;

   // Input command codes
   localparam logic CMD_BYTE  = 1'b0;
   localparam logic CMD_FETCH = 1'b1;

   // Result kinds
   localparam logic [1:0] KIND_ECHO = 2'd0;
   localparam logic [1:0] KIND_CMD  = 2'd1;
   localparam logic [1:0] KIND_NONE = 2'd2;

   // Line status codes
   localparam logic [1:0] ST_CLEAR     = 2'd0;
   localparam logic [1:0] ST_RECEIVING = 2'd1;
   localparam logic [1:0] ST_RECEIVED  = 2'd2;

   // Result sequence being played out
   typedef enum logic [2:0] {
      SEQ_CHAR  = 3'd0,
      SEQ_BS    = 3'd1,
      SEQ_EOL   = 3'd2,
      SEQ_NONE  = 3'd3,
      SEQ_FETCH = 3'd4
   } seq_type;

   // Controller -> datapath
   typedef struct packed {
      logic capture;   // latch the incoming item
      logic update;    // apply the item to the line state, pick sequence
      logic emit;      // load the next result into the output register
   } ctl_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic no_result; // latched item produces nothing
      logic seq_last;  // current sequence step is the final one
      logic out_free;  // output register can take a result this cycle
   } ctl_sts_type;

endpackage

`default_nettype wire

// ===== rtl/scle_ctrl.sv =====
// Sequencing controller for the serial command line editor.
// Depends on scle_pkg; drives the datapath through ctl_cmd_type.
`timescale 1ns / 1ps
`default_nettype none

module scle_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire scle_pkg::ctl_sts_type sts,
   output scle_pkg::ctl_cmd_type     cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_DECODE = 4'b0010,
      S_READ   = 4'b0100,
      S_EMIT   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.update  = 1'b0;
      cmd.emit    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            cmd.update = 1'b1;
            state_in   = sts.no_result ? S_IDLE : S_READ;
         end
         S_READ: begin
            // store read data lands this cycle
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = sts.seq_last ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/scle_dp.sv =====
// Datapath of the serial command line editor: line memory, length and
// status registers, result sequencing and the output register. Uses scle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scle_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire scle_pkg::ctl_cmd_type cmd,
   output scle_pkg::ctl_sts_type     sts,
   input  wire logic                 req_command,
   input  wire logic [7:0]           req_rx_byte,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [1:0]                rsp_kind,
   output logic [7:0]                rsp_data,
   output logic                      rsp_last,
   output logic [1:0]                rsp_line_status
);

   localparam int LW = scle_pkg::LEN_W;

   // Line memory; it also serves as the command store (see top level).
   logic [7:0] line_mem [scle_pkg::LINE_DEPTH];
   logic [7:0] rd_data_ff;

   logic          item_cmd_ff;
   logic [7:0]    item_byte_ff;

   logic [LW-1:0] len_ff, len_in;
   logic          zero_seen_ff, zero_seen_in;
   logic [LW-1:0] zero_pos_ff, zero_pos_in;
   logic [LW-1:0] cmd_len_ff, cmd_len_in;
   logic [1:0]    status_ff, status_in;

   scle_pkg::seq_type seq_ff, seq_in;
   logic [LW-1:0]     idx_ff, idx_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_kind_ff;
   logic [7:0]    rsp_data_ff;
   logic          rsp_last_ff;
   logic [1:0]    rsp_status_ff;

   logic          is_fetch, is_drop, is_bs, is_eol, is_char;
   logic [LW-1:0] len_dec;
   logic [1:0]    emit_kind;
   logic [7:0]    emit_data;
   logic          seq_last;

   // Item classification
   always_comb begin
      is_fetch = (item_cmd_ff == scle_pkg::CMD_FETCH);
      is_drop  = !is_fetch && item_byte_ff[7];
      is_bs    = !is_fetch && !is_drop && (item_byte_ff == scle_pkg::CH_BS);
      is_eol   = !is_fetch && !is_drop && !is_bs &&
                 ((item_byte_ff == scle_pkg::CH_LF) || (item_byte_ff == scle_pkg::CH_CR) ||
                  (len_ff >= scle_pkg::FULL_LEN));
      is_char  = !is_fetch && !is_drop && !is_bs && !is_eol;
      len_dec  = len_ff - LW'(1);
   end

   // Line state update
   always_comb begin
      len_in       = len_ff;
      zero_seen_in = zero_seen_ff;
      zero_pos_in  = zero_pos_ff;
      cmd_len_in   = cmd_len_ff;
      status_in    = status_ff;
      seq_in       = seq_ff;
      idx_in       = idx_ff;
      if (cmd.update) begin
         idx_in = '0;
         priority if (is_fetch) begin
            if (status_ff == scle_pkg::ST_RECEIVED) begin
               seq_in    = scle_pkg::SEQ_FETCH;
               status_in = scle_pkg::ST_CLEAR;
            end else begin
               seq_in = scle_pkg::SEQ_NONE;
            end
         end else if (is_drop) begin
            seq_in = scle_pkg::SEQ_NONE;
         end else if (is_bs) begin
            seq_in = scle_pkg::SEQ_BS;
            if (len_ff != '0) begin
               len_in = len_dec;
               // the first zero was the last char: no zero left
               if (zero_seen_ff && (zero_pos_ff == len_dec)) zero_seen_in = 1'b0;
            end
         end else if (is_eol) begin
            seq_in       = scle_pkg::SEQ_EOL;
            cmd_len_in   = zero_seen_ff ? zero_pos_ff : len_ff;
            len_in       = '0;
            zero_seen_in = 1'b0;
            status_in    = scle_pkg::ST_RECEIVED;
         end else begin
            seq_in    = scle_pkg::SEQ_CHAR;
            len_in    = len_ff + LW'(1);
            status_in = scle_pkg::ST_RECEIVING;
            if ((item_byte_ff == scle_pkg::CH_NUL) && !zero_seen_ff) begin
               zero_seen_in = 1'b1;
               zero_pos_in  = len_ff;
            end
         end
      end else if (cmd.emit) begin
         idx_in = idx_ff + LW'(1);
      end
   end

   // Current result of the sequence
   always_comb begin
      emit_kind = scle_pkg::KIND_ECHO;
      emit_data = item_byte_ff;
      seq_last  = 1'b1;
      unique case (seq_ff)
         scle_pkg::SEQ_CHAR: begin
            emit_data = item_byte_ff;
         end
         scle_pkg::SEQ_BS: begin
            emit_data = (idx_ff == LW'(1)) ? scle_pkg::CH_SP : scle_pkg::CH_BS;
            seq_last  = (idx_ff == LW'(2));
         end
         scle_pkg::SEQ_EOL: begin
            emit_data = (idx_ff == '0) ? scle_pkg::CH_CR : scle_pkg::CH_LF;
            seq_last  = (idx_ff == LW'(1));
         end
         scle_pkg::SEQ_NONE: begin
            emit_kind = scle_pkg::KIND_NONE;
            emit_data = scle_pkg::CH_NUL;
         end
         scle_pkg::SEQ_FETCH: begin
            emit_kind = scle_pkg::KIND_CMD;
            seq_last  = (idx_ff == cmd_len_ff);
            emit_data = seq_last ? scle_pkg::CH_NUL : rd_data_ff;
         end
         default: begin
            emit_kind = scle_pkg::KIND_NONE;
            emit_data = scle_pkg::CH_NUL;
         end
      endcase
   end

   assign sts.seq_last  = seq_last;
   assign sts.no_result = is_drop || (is_bs && (len_ff == '0));
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit)      rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   // Line memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.update && is_char) line_mem[len_ff] <= item_byte_ff;
      rd_data_ff <= line_mem[idx_ff];
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_cmd_ff  <= req_command;
         item_byte_ff <= req_rx_byte;
      end
      if (cmd.emit) begin
         rsp_kind_ff   <= emit_kind;
         rsp_data_ff   <= emit_data;
         rsp_last_ff   <= seq_last;
         rsp_status_ff <= status_ff;
      end
      zero_pos_ff <= zero_pos_in;
      seq_ff      <= seq_in;
      idx_ff      <= idx_in;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         zero_seen_ff <= 1'b0;
         cmd_len_ff   <= '0;
         status_ff    <= scle_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         zero_seen_ff <= zero_seen_in;
         cmd_len_ff   <= cmd_len_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_data        = rsp_data_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_line_status = rsp_status_ff;

endmodule

`default_nettype wire

// ===== rtl/serial_command_line_editor.sv =====
// Top level of the serial command line editor: controller plus datapath.
// Depends on scle_pkg, scle_ctrl and scle_dp.
//
// Input channel (req_): one item is either a received serial byte
// (req_command = 0, byte on req_rx_byte) or a fetch of the completed
// command (req_command = 1). Result channel (rsp_): zero or more items per
// input item; rsp_last marks the final one, rsp_line_status carries the
// line status after that input item.
// Timing: an input item is accepted in the idle state and decoded in the
// next cycle; then each result passes through a memory-read state and an
// output-load state, which waits while the output register is full. No new
// item is accepted until the last result is loaded. Bytes that give nothing
// (above 0x7F, backspace on an empty line) return to idle after decode. A
// fetch gives up to LINE_DEPTH-1 results, so the line memory's single read
// port sets the rate of a readout.
// The completed command is read straight from the line memory: it stays
// intact until the next stored character, which also drops the status to
// receiving and so makes the old command unreachable. Its length is the
// line length, or the position of the first zero byte if one was typed.
// Reset: line empty, no command, status clear, no result pending; no
// clearing pass is needed. A stalled receiver holds the current result in
// the output register; the block waits to load the next one until it moves.
`timescale 1ns / 1ps
`default_nettype none

module serial_command_line_editor (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_command,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [1:0]      rsp_kind,
   output logic [7:0]      rsp_data,
   output logic            rsp_last,
   output logic [1:0]      rsp_line_status
);

   scle_pkg::ctl_cmd_type cmd;
   scle_pkg::ctl_sts_type sts;

   scle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   scle_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_command     (req_command),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_data        (rsp_data),
      .rsp_last        (rsp_last),
      .rsp_line_status (rsp_line_status)
   );

   // One item at a time: no acceptance right after an acceptance.
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted while previous item in progress");

   // A no-command result stands alone.
   a_none_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == scle_pkg::KIND_NONE)) |-> rsp_last)
      else $error("no-command result not marked last");

   // A readout ends in a zero terminator and leaves the status clear.
   a_fetch_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == scle_pkg::KIND_CMD) && rsp_last) |->
      ((rsp_data == scle_pkg::CH_NUL) && (rsp_line_status == scle_pkg::ST_CLEAR)))
      else $error("command readout end malformed");

   // Command bytes only ever report a cleared status.
   a_fetch_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == scle_pkg::KIND_CMD)) |->
      (rsp_line_status == scle_pkg::ST_CLEAR))
      else $error("command byte with status not clear");

endmodule

`default_nettype wire

// ===== tb/line_editor_checker.sv =====
// Result checker for the serial command line editor: follows the line and
// command state from accepted input items and compares every result item.
// Depends on scle_pkg.
`timescale 1ns / 1ps

module line_editor_checker
   import scle_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic       req_command,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic [1:0] rsp_kind,
   input  wire logic [7:0] rsp_data,
   input  wire logic       rsp_last,
   input  wire logic [1:0] rsp_line_status,
   output int              error_count,
   output int              pending
);

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
      logic [1:0] status;
   } editor_result_type;

   logic [7:0]        line_chars [LINE_DEPTH];
   int                line_len;
   logic [7:0]        command_chars [LINE_DEPTH];
   int                command_len;
   logic [1:0]        line_state;
   editor_result_type expected_results [$];

   function automatic editor_result_type make_result(input logic [1:0] kind,
                                                     input logic [7:0] data);
      editor_result_type r;
      r      = '0;
      r.kind = kind;
      r.data = data;
      return r;
   endfunction

   // Applies one accepted item to the tracked state, queues its results.
   task automatic predict_item(input logic cmd, input logic [7:0] ch);
      editor_result_type step_results [$];
      int                i;
      if (cmd == CMD_FETCH) begin
         if (line_state == ST_RECEIVED) begin
            for (i = 0; i < command_len; i++)
               step_results.push_back(make_result(KIND_CMD, command_chars[i]));
            step_results.push_back(make_result(KIND_CMD, CH_NUL));
            line_state = ST_CLEAR;
         end else begin
            step_results.push_back(make_result(KIND_NONE, CH_NUL));
         end
      end else if (ch > 8'h7F) begin
         // dropped without a trace
      end else if (ch == CH_BS) begin
         if (line_len > 0) begin
            line_len--;
            line_chars[line_len] = CH_NUL;
            step_results.push_back(make_result(KIND_ECHO, CH_BS));
            step_results.push_back(make_result(KIND_ECHO, CH_SP));
            step_results.push_back(make_result(KIND_ECHO, CH_BS));
         end
      end else if (ch == CH_LF || ch == CH_CR || line_len >= int'(FULL_LEN)) begin
         // end of line; command stops at the first zero byte
         i = 0;
         while (i < line_len && line_chars[i] != CH_NUL) begin
            command_chars[i] = line_chars[i];
            i++;
         end
         command_len = i;
         line_len    = 0;
         line_state  = ST_RECEIVED;
         step_results.push_back(make_result(KIND_ECHO, CH_CR));
         step_results.push_back(make_result(KIND_ECHO, CH_LF));
      end else begin
         line_chars[line_len] = ch;
         line_len++;
         line_state = ST_RECEIVING;
         step_results.push_back(make_result(KIND_ECHO, ch));
      end
      foreach (step_results[k]) begin
         step_results[k].status = line_state;
         step_results[k].last   = (k == step_results.size() - 1);
         expected_results.push_back(step_results[k]);
      end
   endtask

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("%0t: mismatch: %s", $time, msg);
   endtask

   task automatic check_result(input editor_result_type want);
      if (rsp_kind !== want.kind)
         report_mismatch($sformatf("kind %0d, expected %0d", rsp_kind, want.kind));
      if (rsp_data !== want.data)
         report_mismatch($sformatf("data %h, expected %h", rsp_data, want.data));
      if (rsp_last !== want.last)
         report_mismatch($sformatf("last %b, expected %b", rsp_last, want.last));
      if (rsp_line_status !== want.status)
         report_mismatch($sformatf("line_status %0d, expected %0d",
                                   rsp_line_status, want.status));
   endtask

   always @(posedge clock) begin : monitor
      editor_result_type want;
      if (reset) begin
         line_len    = 0;
         command_len = 0;
         line_state  = ST_CLEAR;
         error_count = 0;
         expected_results.delete();
         foreach (line_chars[i]) begin
            line_chars[i]    = CH_NUL;
            command_chars[i] = CH_NUL;
         end
      end else begin
         // new expectations go to the back, so an item accepted on the same
         // edge never jumps ahead of older ones
         if (req_valid && req_ready)
            predict_item(req_command, req_rx_byte);
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result kind %0d data %h",
                                         rsp_kind, rsp_data));
            end else begin
               want = expected_results.pop_front();
               check_result(want);
            end
         end
      end
      pending = expected_results.size();
   end

endmodule

// ===== tb/testbench.sv =====
// Top of the serial command line editor testbench: clock, reset, stimulus
// and verdict. Depends on scle_pkg, serial_command_line_editor and
// line_editor_checker.
`timescale 1ns / 1ps

module testbench;
   import scle_pkg::*;

   localparam int ITEM_TARGET      = 450;   // items that reach the editor
   localparam int QUIET_ITEMS      = 60;    // final stretch without idling
   localparam int LONG_HOLD_AT     = 150;   // item count that starts the hold-off
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT   = 2000;  // cycles without any handshake
   localparam int DRAIN_CYCLES     = 16;    // drain after the last expected result
   localparam int RESET_CYCLES     = 6;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_command;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_data;
   logic       rsp_last;
   logic [1:0] rsp_line_status;

   int error_count;
   int pending;
   int items_sent    = 0;
   int idle_cycles   = 0;
   bit quiet         = 1'b0;
   bit long_hold_req = 1'b0;
   bit long_hold_done = 1'b0;

   always #10 clock = ~clock;

   serial_command_line_editor dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_data        (rsp_data),
      .rsp_last        (rsp_last),
      .rsp_line_status (rsp_line_status)
   );

   line_editor_checker line_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_data        (rsp_data),
      .rsp_last        (rsp_last),
      .rsp_line_status (rsp_line_status),
      .error_count     (error_count),
      .pending         (pending)
   );

   // Watchdog: any handshake on either channel restarts the count, so only
   // a real hang (or a lost result) trips it.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Receiver: random stall bursts, one long hold-off so the editor fills
   // up and backs up its input, and no stalls in the final stretch.
   initial begin : receiver
      rsp_ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         @(posedge clock);
         if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offers one item and holds it until accepted. Valid is only dropped
   // when an idle burst follows, so back-to-back items keep it high.
   task automatic send_item(input logic cmd, input logic [7:0] ch);
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_rx_byte <= ch;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      // bytes above 0x7F are ignored by the editor and do not count
      if (cmd == CMD_FETCH || ch <= 8'h7F)
         items_sent++;
      quiet = (items_sent >= ITEM_TARGET - QUIET_ITEMS);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // Types a line of mostly printable characters, with some backspaces,
   // dropped high bytes, zero bytes, DEL and control codes mixed in.
   task automatic type_line(input int n_chars, input bit terminate);
      int         i;
      int         r;
      logic [7:0] ch;
      for (i = 0; i < n_chars; i++) begin
         r = $urandom_range(0, 99);
         if (r < 80)      ch = 8'($urandom_range(8'h20, 8'h7E));
         else if (r < 86) ch = CH_BS;
         else if (r < 90) ch = 8'($urandom_range(8'h80, 8'hFF));
         else if (r < 93) ch = CH_NUL;
         else if (r < 96) ch = 8'h7F;
         else             ch = 8'($urandom_range(8'h01, 8'h1F));
         send_item(CMD_BYTE, ch);
      end
      if (terminate)
         send_item(CMD_BYTE, $urandom_range(0, 1) ? CH_CR : CH_LF);
   endtask

   initial begin : stimulus
      int r;
      int n;
      bit term;

      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_command <= CMD_BYTE;
      req_rx_byte <= CH_NUL;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      send_item(CMD_FETCH, 8'hFF);   // fetch before any line: no command
      send_item(CMD_BYTE, CH_BS);    // backspace on an empty line
      send_item(CMD_BYTE, 8'hFF);    // high bytes are dropped
      send_item(CMD_BYTE, 8'h80);
      send_item(CMD_BYTE, 8'h61);
      send_item(CMD_BYTE, 8'h7F);
      send_item(CMD_BYTE, CH_NUL);   // zero byte cuts the command short
      send_item(CMD_BYTE, 8'h62);
      send_item(CMD_BYTE, CH_CR);
      send_item(CMD_FETCH, 8'h00);   // gives the command and terminator
      send_item(CMD_FETCH, 8'h00);   // status cleared: no command again
      send_item(CMD_BYTE, CH_LF);    // empty line ended
      send_item(CMD_FETCH, 8'h55);   // terminator only
      send_item(CMD_BYTE, 8'h78);
      send_item(CMD_BYTE, CH_BS);    // backspace keeps receiving status
      send_item(CMD_BYTE, 8'h79);
      send_item(CMD_BYTE, CH_CR);
      send_item(CMD_BYTE, 8'h7A);    // typing hides the finished command
      send_item(CMD_FETCH, 8'hAA);
      send_item(CMD_BYTE, CH_BS);
      send_item(CMD_BYTE, CH_BS);    // back on an empty line

      // --- random part: mostly complete lines followed by a fetch ---
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= LONG_HOLD_AT && !long_hold_req)
            long_hold_req <= 1'b1;
         r = $urandom_range(0, 99);
         if (r < 70)      n = $urandom_range(0, 10);
         else if (r < 85) n = $urandom_range(11, 25);
         else             n = $urandom_range(26, 34);  // can reach the full line
         // long lines sometimes end by filling up rather than by CR/LF
         term = (n < 26) || ($urandom_range(0, 1) == 1);
         r = $urandom_range(0, 99);
         if (r < 75) begin
            type_line(n, term);
            send_item(CMD_FETCH, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 4) == 0)
               send_item(CMD_FETCH, 8'($urandom_range(0, 255)));
         end else if (r < 88) begin
            // more typing after a finished line, then a fetch that mostly misses
            type_line(n, 1'b1);
            type_line($urandom_range(1, 4), 1'b0);
            send_item(CMD_FETCH, 8'($urandom_range(0, 255)));
         end else begin
            // noise: any command, any byte
            repeat ($urandom_range(1, 5))
               send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end
      end
      req_valid <= 1'b0;

      // wait for the last results, then a short drain for strays
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== serial_command_line_editor.f =====
rtl/scle_pkg.sv
rtl/scle_ctrl.sv
rtl/scle_dp.sv
rtl/serial_command_line_editor.sv
tb/line_editor_checker.sv
tb/testbench.sv
